FILE: sv/asn1ts_pkg.sv
// Shared types, character codes and field limits for the ASN.1 time string parser.
package asn1ts_pkg;

	localparam int StoreDepth  = 14;
	localparam int AddrWidth   = $clog2(StoreDepth);
	localparam int CountSat    = 16;
	localparam int CountWidth  = $clog2(CountSat + 1);
	localparam int UtcLen      = 13;
	localparam int GenLen      = 15;
	localparam int YearPivot   = 50;
	localparam int Century19   = 1900;
	localparam int Century20   = 2000;
	localparam int MonthMax    = 12;
	localparam int DayMax      = 31;
	localparam int HourLimit   = 24;
	localparam int MinSecLimit = 60;

	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;
	localparam logic [7:0] CharZ    = 8'h5A;

	localparam logic [1:0] StatusOk          = 2'd0;
	localparam logic [1:0] StatusUnsupported = 2'd1;
	localparam logic [1:0] StatusInvalid     = 2'd2;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} result_t;

	function automatic logic [6:0] pair_val(input digit_t hi, input digit_t lo);
		logic [6:0] h;
		h = {3'b000, hi};
		return (h << 3) + (h << 1) + {3'b000, lo};
	endfunction

endpackage

FILE: sv/asn1ts_if.sv
// Handshake interfaces for the character stream and the decoded time result.
interface asn1ts_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

interface asn1ts_time_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	modport source(output valid, output status, output year, output month, output day,
		output hour, output minute, output second, input ready);
	modport sink(input valid, input status, input year, input month, input day,
		input hour, input minute, input second, output ready);
endinterface

FILE: sv/asn1ts_decode.sv
// Combinational decode of the stored digits into a status and calendar fields.
module asn1ts_decode (
	input  asn1ts_pkg::digit_t                          digits [asn1ts_pkg::StoreDepth],
	input  logic [asn1ts_pkg::CountWidth-1:0]           count,
	input  logic                                        saw_nondigit,
	input  logic [7:0]                                  character,
	output asn1ts_pkg::result_t                         result
);
	import asn1ts_pkg::*;

	logic        gen_len;
	logic        utc_len;
	logic [6:0]  p_hi;
	logic [6:0]  p_lo;
	logic [6:0]  p_month;
	logic [6:0]  p_day;
	logic [6:0]  p_hour;
	logic [6:0]  p_minute;
	logic [6:0]  p_second;
	logic [13:0] year_gen;
	logic [13:0] year_utc;
	logic [13:0] year_v;
	logic        range_bad;

	assign gen_len = (count == CountWidth'(GenLen - 1));
	assign utc_len = (count == CountWidth'(UtcLen - 1));

	assign p_hi     = pair_val(digits[0], digits[1]);
	assign p_lo     = pair_val(digits[2], digits[3]);
	assign p_month  = gen_len ? pair_val(digits[4], digits[5])   : p_lo;
	assign p_day    = gen_len ? pair_val(digits[6], digits[7])   : pair_val(digits[4], digits[5]);
	assign p_hour   = gen_len ? pair_val(digits[8], digits[9])   : pair_val(digits[6], digits[7]);
	assign p_minute = gen_len ? pair_val(digits[10], digits[11]) : pair_val(digits[8], digits[9]);
	assign p_second = gen_len ? pair_val(digits[12], digits[13]) : pair_val(digits[10], digits[11]);

	assign year_gen = ({7'b0, p_hi} << 6) + ({7'b0, p_hi} << 5) + ({7'b0, p_hi} << 2)
		+ {7'b0, p_lo};
	assign year_utc = {7'b0, p_hi}
		+ ((p_hi >= 7'(YearPivot)) ? 14'(Century19) : 14'(Century20));
	assign year_v   = gen_len ? year_gen : year_utc;

	assign range_bad = (p_month == 7'd0) || (p_month > 7'(MonthMax))
		|| (p_day == 7'd0) || (p_day > 7'(DayMax))
		|| (p_hour >= 7'(HourLimit)) || (p_minute >= 7'(MinSecLimit))
		|| (p_second >= 7'(MinSecLimit));

	always_comb begin
		result = '0;
		priority if (!gen_len && !utc_len) begin
			result.status = StatusUnsupported;
		end else if (character != CharZ) begin
			result.status = StatusUnsupported;
		end else if (saw_nondigit) begin
			result.status = StatusInvalid;
		end else if (range_bad) begin
			result.status = StatusInvalid;
		end else begin
			result.status = StatusOk;
			result.year   = year_v;
			result.month  = p_month[3:0];
			result.day    = p_day[4:0];
			result.hour   = p_hour[4:0];
			result.minute = p_minute[5:0];
			result.second = p_second[5:0];
		end
	end

endmodule

FILE: sv/asn1_time_string_parser_unit.sv
// Top level of the ASN.1 UTCTime / GeneralizedTime parser.
// The unit takes one character word per clock, except while a stalled output holds back a last
// character, and otherwise keeps up with the stream at full rate. Each accepted character is
// captured in an input register and from there either updates the running digit store and
// counters or, for the word marked last, is decoded into a result word that lands in the output
// register, from which it is offered. Exactly one result word comes out per string, and a
// stalled output only holds back the last character of the following string.
module asn1_time_string_parser_unit (
	input  logic          clk,
	input  logic          arst_n,
	asn1ts_char_if.sink   text,
	asn1ts_time_if.source stamp
);
	import asn1ts_pkg::*;

	logic                  valid_s1;
	logic [7:0]            char_s1;
	logic                  last_s1;
	logic [CountWidth-1:0] count_q;
	logic                  nondigit_q;
	digit_t                digits_q [StoreDepth];
	result_t               res_q;
	logic                  out_valid_q;
	result_t               dec;
	logic                  out_free;
	logic                  s1_go;
	logic                  is_digit;

	assign out_free   = !out_valid_q || stamp.ready;
	assign s1_go      = valid_s1 && (!last_s1 || out_free);
	assign text.ready = !valid_s1 || s1_go;
	assign is_digit   = (char_s1 >= CharZero) && (char_s1 <= CharNine);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.valid && text.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.character;
			last_s1 <= text.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			nondigit_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				count_q    <= '0;
				nondigit_q <= 1'b0;
			end else begin
				if (!is_digit) begin
					nondigit_q <= 1'b1;
				end
				if (count_q < CountWidth'(CountSat)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && !last_s1 && (count_q < CountWidth'(StoreDepth))) begin
			digits_q[count_q[AddrWidth-1:0]] <= is_digit ? 4'(char_s1 - CharZero) : 4'd0;
		end
	end

	asn1ts_decode u_decode (
		.digits       (digits_q),
		.count        (count_q),
		.saw_nondigit (nondigit_q),
		.character    (char_s1),
		.result       (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (stamp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			res_q <= dec;
		end
	end

	assign stamp.valid  = out_valid_q;
	assign stamp.status = res_q.status;
	assign stamp.year   = res_q.year;
	assign stamp.month  = res_q.month;
	assign stamp.day    = res_q.day;
	assign stamp.hour   = res_q.hour;
	assign stamp.minute = res_q.minute;
	assign stamp.second = res_q.second;

endmodule

FILE: sv/asn1ts_checker.sv
// Port-level assertions for the time string parser and their binding to the top level.
module asn1ts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [13:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second
);
	import asn1ts_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(year)
			&& $stable(month) && $stable(day) && $stable(hour) && $stable(minute)
			&& $stable(second))
		else $error("Stalled result word changed.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == StatusOk) || (status == StatusUnsupported)
			|| (status == StatusInvalid))
		else $error("Result status outside the defined codes.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != StatusOk) |-> (year == 14'd0) && (month == 4'd0)
			&& (day == 5'd0) && (hour == 5'd0) && (minute == 6'd0) && (second == 6'd0))
		else $error("Error result carries nonzero date fields.");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == StatusOk) |-> (month != 4'd0) && (month <= 4'(MonthMax))
			&& (day != 5'd0) && (hour < 5'(HourLimit)) && (minute < 6'(MinSecLimit))
			&& (second < 6'(MinSecLimit)))
		else $error("Good result has a field out of range.");

endmodule

bind asn1_time_string_parser_unit asn1ts_checker u_asn1ts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (stamp.valid),
	.out_ready (stamp.ready),
	.status    (stamp.status),
	.year      (stamp.year),
	.month     (stamp.month),
	.day       (stamp.day),
	.hour      (stamp.hour),
	.minute    (stamp.minute),
	.second    (stamp.second)
);
